// ===== rtl/core/srfe_pkg.sv =====
// Package for the shape raster fill engine: sizes, opcodes, register indexes, sequencer states.
`default_nettype none
package srfe_pkg;

  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;

  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  // signed coordinates: covers diamond rows up to 765
  localparam int COORD_W = 12;
  localparam int ROWS_W  = 11;
  localparam int CNT_W   = 15;
  localparam int CFG_IDX_W = 2;

  localparam logic [7:0] FILL_CHAR = 8'd46;

  localparam logic [2:0] OP_CLEAR   = 3'd0;
  localparam logic [2:0] OP_RECT    = 3'd1;
  localparam logic [2:0] OP_TRI_UP  = 3'd2;
  localparam logic [2:0] OP_TRI_DN  = 3'd3;
  localparam logic [2:0] OP_DIAMOND = 3'd4;
  localparam logic [2:0] OP_READ    = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 2'd1;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_ROW,
    ST_SPAN,
    ST_RD_WAIT,
    ST_RESULT
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/shape_raster_fill_engine.sv =====
// Shape raster fill engine: span sequencer over a character frame store.
//
//  channel   | signals                                            | dir
//  ----------+----------------------------------------------------+-----
//  command   | start, busy, opcode, x_pos, y_pos, extent_a/b,brush | in; busy out
//  result    | done, read_value, pixels_written                   | out
//  config    | cfg_we, cfg_index, cfg_data                        | in
//
// A command is taken when start is high and busy is low. After that busy stays
// high while the row walk steps through its rows, writing each pixel on the single
// memory write port, while it closes the walk and while the result is shown; a
// read waits for the memory read before its result, and an unused opcode goes
// straight to its result. After reset a clearing pass writes '.' into all
// MAX_WIDTH*MAX_HEIGHT entries with busy high; config writes are taken at any time.
// done is high for one cycle with the result; the receiver cannot stall it.
`default_nettype none
module shape_raster_fill_engine (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [2:0]                     opcode,
  input  wire logic signed [8:0]              x_pos,
  input  wire logic signed [8:0]              y_pos,
  input  wire logic [7:0]                     extent_a,
  input  wire logic [7:0]                     extent_b,
  input  wire logic [7:0]                     brush,
  output logic                                done,
  output logic [7:0]                          read_value,
  output logic [srfe_pkg::CNT_W-1:0]          pixels_written,
  input  wire logic                           cfg_we,
  input  wire logic [srfe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                     cfg_data
);
  import srfe_pkg::*;

  state_t state, state_next;

  logic [7:0] canvas_width, canvas_height;

  logic [7:0] mem [DEPTH];
  logic [7:0] mem_q;
  logic [ADDR_W-1:0] raddr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;

  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] addr;
  logic signed [COORD_W-1:0] row_y, lo, hi, col, col_end;
  logic [ROWS_W-1:0] rows_left;
  logic [7:0]        grow_left;
  logic              widen, dy_neg;
  logic [7:0]        brush_q;
  logic [CNT_W-1:0]  cnt;
  logic              rd_ok;

  logic signed [COORD_W-1:0] act_w, act_h, w_last, clo, chi;
  logic signed [COORD_W-1:0] x_ext, y_ext;
  logic [COORD_W-1:0]        ea_ext;
  logic row_hit, rd_hit, accept;

  logic [7:0]                cmd_brush;
  logic signed [COORD_W-1:0] cmd_row, cmd_lo, cmd_hi;
  logic                      cmd_widen, cmd_dy_neg;
  logic [ROWS_W-1:0]         cmd_rows;

  // effective canvas size, saturated to the store size
  always_comb begin
    act_w = {{(COORD_W-8){1'b0}}, canvas_width};
    act_h = {{(COORD_W-8){1'b0}}, canvas_height};
    if (act_w > COORD_W'(MAX_WIDTH))  act_w = COORD_W'(MAX_WIDTH);
    if (act_h > COORD_W'(MAX_HEIGHT)) act_h = COORD_W'(MAX_HEIGHT);
    w_last = act_w - 1'b1;
  end

  assign x_ext  = {{(COORD_W-9){x_pos[8]}}, x_pos};
  assign y_ext  = {{(COORD_W-9){y_pos[8]}}, y_pos};
  assign ea_ext = {{(COORD_W-8){1'b0}}, extent_a};
  assign accept = start && (state == ST_IDLE);

  // starting row walk for the request at the inputs
  always_comb begin
    cmd_brush  = brush;
    cmd_row    = y_ext;
    cmd_lo     = x_ext;
    cmd_hi     = x_ext;
    cmd_widen  = 1'b1;
    cmd_dy_neg = 1'b0;
    cmd_rows   = {{(ROWS_W-8){1'b0}}, extent_a};
    case (opcode)
      OP_CLEAR: begin
        cmd_brush = FILL_CHAR;
        cmd_row   = '0;
        cmd_lo    = '0;
        cmd_hi    = w_last;
        cmd_widen = 1'b0;
        cmd_rows  = act_h[ROWS_W-1:0];
      end
      OP_RECT: begin
        cmd_hi    = x_ext + ea_ext - 1'b1;
        cmd_widen = 1'b0;
        cmd_rows  = {{(ROWS_W-8){1'b0}}, extent_b};
      end
      OP_TRI_DN:  cmd_dy_neg = 1'b1;
      OP_DIAMOND: cmd_rows = {{(ROWS_W-9){1'b0}}, extent_a, 1'b1};
      default: ;
    endcase
  end

  // span clipping for the current row
  assign clo     = lo[COORD_W-1] ? '0 : lo;
  assign chi     = (hi > w_last) ? w_last : hi;
  assign row_hit = !row_y[COORD_W-1] && (row_y < act_h) && (clo <= chi);
  assign rd_hit  = !x_ext[COORD_W-1] && !y_ext[COORD_W-1] && (x_ext < act_w) && (y_ext < act_h);

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= 8'd128;
      canvas_height <= 8'd128;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CANVAS_WIDTH:  canvas_width  <= cfg_data;
        REG_CANVAS_HEIGHT: canvas_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_INIT;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: if (clr_addr == ADDR_W'(DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (start) begin
          case (opcode)
            OP_CLEAR, OP_RECT, OP_TRI_UP, OP_TRI_DN, OP_DIAMOND: state_next = ST_ROW;
            OP_READ: state_next = ST_RD_WAIT;
            default: state_next = ST_RESULT;
          endcase
        end
      end
      ST_ROW: begin
        if (rows_left == '0) state_next = ST_RESULT;
        else if (row_hit)    state_next = ST_SPAN;
      end
      ST_SPAN:    if (col == col_end) state_next = ST_ROW;
      ST_RD_WAIT: state_next = ST_RESULT;
      ST_RESULT:  state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else begin
      case (state)
        ST_INIT: clr_addr <= clr_addr + 1'b1;
        ST_IDLE: begin
          if (accept) begin
            cnt       <= '0;
            rd_ok     <= (opcode == OP_READ) && rd_hit;
            raddr     <= ADDR_W'(y_ext[ROW_W-1:0]) * ADDR_W'(MAX_WIDTH)
                       + ADDR_W'(x_ext[COL_W-1:0]);
            brush_q   <= cmd_brush;
            row_y     <= cmd_row;
            lo        <= cmd_lo;
            hi        <= cmd_hi;
            widen     <= cmd_widen;
            dy_neg    <= cmd_dy_neg;
            grow_left <= extent_a;
            rows_left <= cmd_rows;
          end
        end
        ST_ROW, ST_SPAN: begin
          if (state == ST_ROW && rows_left != '0 && row_hit) begin
            col     <= clo;
            col_end <= chi;
            addr    <= ADDR_W'(row_y[ROW_W-1:0]) * ADDR_W'(MAX_WIDTH)
                     + ADDR_W'(clo[COL_W-1:0]);
          end else if (state == ST_SPAN && col != col_end) begin
            col  <= col + 1'b1;
            addr <= addr + 1'b1;
          end
          if (state == ST_SPAN) cnt <= cnt + 1'b1;
          // step to the next row when the row is skipped or its span ends
          if ((state == ST_ROW && rows_left != '0 && !row_hit) ||
              (state == ST_SPAN && col == col_end)) begin
            rows_left <= rows_left - 1'b1;
            row_y     <= dy_neg ? row_y - 1'b1 : row_y + 1'b1;
            if (widen) begin
              if (grow_left != '0) begin
                lo        <= lo - 1'b1;
                hi        <= hi + 1'b1;
                grow_left <= grow_left - 1'b1;
              end else begin
                lo <= lo + 1'b1;
                hi <= hi - 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    mem_we    = (state == ST_INIT) || (state == ST_SPAN);
    mem_waddr = (state == ST_INIT) ? clr_addr : addr;
    mem_wdata = (state == ST_INIT) ? FILL_CHAR : brush_q;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_q <= mem[raddr];
  end

  assign busy           = (state != ST_IDLE);
  assign done           = (state == ST_RESULT);
  assign read_value     = (done && rd_ok) ? mem_q : 8'd0;
  assign pixels_written = cnt;

endmodule
`default_nettype wire
